// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the next cycle, switched off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked in the next cycle, checked through reset as well
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rm2q_pkg.sv -----
// shared constants, types and arithmetic steps for the matrix to quaternion block
package rm2q_pkg;

  localparam int DW         = 16;
  localparam int FRAC_BITS  = 14;
  localparam int R_W        = DW + 1;
  localparam int MAG_W      = DW + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int Q_W        = SQ_W;
  localparam int SR_W       = Q_W / 2;
  localparam int SREM_W     = SR_W + 2;
  localparam int NSC        = 3;
  localparam int NSQ        = NSC + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int DIN_W      = 9 * DW;
  localparam int DOUT_W     = 4 * DW;

  typedef enum logic [1:0] {PIV_W, PIV_X, PIV_Y, PIV_Z} piv_t;

  typedef struct packed {
    piv_t                   piv;
    logic [R_W-1:0]         rad;
    logic [NSC-1:0][DW:0]   diff;
  } job_t;

  typedef struct packed {
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] num;
  } div_lane_t;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [SR_W-1:0]   root;
    logic [Q_W-1:0]    val;
  } sq_lane_t;

  typedef struct packed {
    piv_t                     piv;
    logic [R_W-1:0]           rad;
    logic [NSC-1:0]           neg;
    div_lane_t [NSC-1:0]      lane;
  } div_stg_t;

  typedef struct packed {
    piv_t                     piv;
    logic [NSC-1:0]           neg;
    sq_lane_t [NSQ-1:0]       lane;
  } sq_stg_t;

  // one restoring division step: quotient bit shifts in where a dividend bit leaves
  function automatic div_lane_t div_step(div_lane_t a, logic [R_W-1:0] den);
    logic [R_W:0] x;
    div_lane_t    b;
    x = {a.rem, a.num[Q_W-1]};
    if (x >= {1'b0, den}) begin
      b.rem = R_W'(x - {1'b0, den});
      b.num = {a.num[Q_W-2:0], 1'b1};
    end else begin
      b.rem = x[R_W-1:0];
      b.num = {a.num[Q_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // one digit of the bitwise integer square root
  function automatic sq_lane_t sqrt_step(sq_lane_t a);
    logic [SREM_W+1:0] x;
    logic [SREM_W+1:0] trial;
    sq_lane_t          b;
    x     = {a.rem, a.val[Q_W-1:Q_W-2]};
    trial = (SREM_W+2)'({a.root, 2'b01});
    if (x >= trial) begin
      b.rem  = SREM_W'(x - trial);
      b.root = {a.root[SR_W-2:0], 1'b1};
    end else begin
      b.rem  = SREM_W'(x);
      b.root = {a.root[SR_W-2:0], 1'b0};
    end
    b.val = {a.val[Q_W-3:0], 2'b00};
    return b;
  endfunction

  // halve with rounding, apply sign, clamp positive results to the output range
  function automatic logic [DW-1:0] rnd_sat(logic [SR_W-1:0] root, logic neg);
    logic [SR_W:0]   inc;
    logic [DW-1:0]   k;
    logic [DW-1:0]   res;
    inc = (SR_W+1)'(root) + (SR_W+1)'(1);
    k   = DW'(inc[SR_W:1]);
    if (neg) begin
      res = -k;
    end else if (k[DW-1]) begin
      res = {1'b0, {(DW-1){1'b1}}};
    end else begin
      res = k;
    end
    return res;
  endfunction

endpackage

// ----- rtl/rotation_matrix_to_quaternion_top.sv -----
// top level of the rotation matrix to quaternion converter
//
// channel   dir   width  contents
// s_*       in    144    matrix elements, row-major, 16-bit signed q2.14
// m_*       out   64     quaternion x, y, z, w, 16-bit signed q2.14
//
// one matrix per cycle sustained while the output is not stalled; stages in order: front register,
// queue, one multiply stage, 34 divide stages, 17 root stages, output register
// the divide and root pipelines set the latency: one quotient bit and one root
// digit per stage; a 4-entry queue lets the front keep taking transfers while
// the output is stalled; rst clears all valid flags
module rotation_matrix_to_quaternion_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
  input  logic [rm2q_pkg::DIN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [rm2q_pkg::DOUT_W-1:0] m_tdata
);
  import rm2q_pkg::*;

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  rm2q_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  rm2q_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fj_valid),
    .in_ready  (fj_ready),
    .in_job    (fj),
    .out_valid (bj_valid),
    .out_ready (bj_ready),
    .out_job   (bj)
  );

  rm2q_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (bj_valid),
    .job_ready (bj_ready),
    .job       (bj),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- rtl/rm2q_front.sv -----
// front end: trace, pivot choice, radicand and off-diagonal pairs
module rm2q_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rm2q_pkg::DIN_W-1:0] s_tdata,
  output logic                      job_valid,
  input  logic                      job_ready,
  output rm2q_pkg::job_t            job
);
  import rm2q_pkg::*;

  localparam int EW = DW + 3;
  localparam logic signed [EW-1:0] ONE_S = EW'(1) <<< FRAC_BITS;

  logic signed [DW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [EW-1:0] e00, e11, e22, tr;
  logic signed [DW:0]   d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
  job_t                 job_next;

  assign a00 = $signed(s_tdata[0*DW +: DW]);
  assign a01 = $signed(s_tdata[1*DW +: DW]);
  assign a02 = $signed(s_tdata[2*DW +: DW]);
  assign a10 = $signed(s_tdata[3*DW +: DW]);
  assign a11 = $signed(s_tdata[4*DW +: DW]);
  assign a12 = $signed(s_tdata[5*DW +: DW]);
  assign a20 = $signed(s_tdata[6*DW +: DW]);
  assign a21 = $signed(s_tdata[7*DW +: DW]);
  assign a22 = $signed(s_tdata[8*DW +: DW]);

  assign e00 = EW'(a00);
  assign e11 = EW'(a11);
  assign e22 = EW'(a22);
  assign tr  = e00 + e11 + e22;

  assign d21m12 = (DW+1)'(a21) - (DW+1)'(a12);
  assign d02m20 = (DW+1)'(a02) - (DW+1)'(a20);
  assign d10m01 = (DW+1)'(a10) - (DW+1)'(a01);
  assign s10p01 = (DW+1)'(a10) + (DW+1)'(a01);
  assign s02p20 = (DW+1)'(a02) + (DW+1)'(a20);
  assign s21p12 = (DW+1)'(a21) + (DW+1)'(a12);

  always_comb begin
    if (!tr[EW-1]) begin
      job_next.piv  = PIV_W;
      job_next.rad  = R_W'(ONE_S + tr);
      job_next.diff = {d10m01, d02m20, d21m12};
    end else if (a00 > a11 && a00 > a22) begin
      job_next.piv  = PIV_X;
      job_next.rad  = R_W'(ONE_S + e00 - e11 - e22);
      job_next.diff = {d21m12, s02p20, s10p01};
    end else if (a11 > a22) begin
      job_next.piv  = PIV_Y;
      job_next.rad  = R_W'(ONE_S + e11 - e00 - e22);
      job_next.diff = {d02m20, s21p12, s10p01};
    end else begin
      job_next.piv  = PIV_Z;
      job_next.rad  = R_W'(ONE_S + e22 - e00 - e11);
      job_next.diff = {d10m01, s21p12, s02p20};
    end
  end

  assign s_tready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s_tready) begin
      job_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      job <= job_next;
    end
  end

endmodule

// ----- rtl/rm2q_fifo.sv -----
// short job queue between front end and arithmetic pipeline
module rm2q_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rm2q_pkg::job_t in_job,
  output logic           out_valid,
  input  logic           out_ready,
  output rm2q_pkg::job_t out_job
);
  import rm2q_pkg::*;

  job_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign in_ready  = count != (PTR_W+1)'(FIFO_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_job;
    end
  end

endmodule

// ----- rtl/rm2q_back.sv -----
// arithmetic pipeline: square, bitwise divide, bitwise root, round and place
module rm2q_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  rm2q_pkg::job_t              job,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [rm2q_pkg::DOUT_W-1:0] m_tdata
);
  import rm2q_pkg::*;

  logic                      adv;
  logic                      mv;
  piv_t                      mpiv;
  logic [R_W-1:0]            mrad;
  logic [NSC-1:0]            mneg;
  logic [NSC-1:0][SQ_W-1:0]  msq;
  logic [NSC-1:0]            neg_in;
  logic [NSC-1:0][MAG_W-1:0] mag_in;

  div_stg_t                  dinit;
  div_stg_t                  dstg [1:Q_W];
  div_stg_t                  dnxt [1:Q_W];
  logic                      dvld [1:Q_W];
  sq_stg_t                   sinit;
  sq_stg_t                   sstg [1:SR_W];
  sq_stg_t                   snxt [1:SR_W];
  logic                      svld [1:SR_W];
  logic [NSQ-1:0][DW-1:0]    qs;
  logic [DW-1:0]             qx, qy, qz, qw;

  assign adv       = !m_tvalid || m_tready;
  assign job_ready = adv;

  always_comb begin
    for (int i = 0; i < NSC; i++) begin
      neg_in[i] = job.diff[i][DW];
      mag_in[i] = neg_in[i] ? MAG_W'(-job.diff[i]) : MAG_W'(job.diff[i]);
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mpiv <= job.piv;
      mrad <= job.rad;
      mneg <= neg_in;
      for (int i = 0; i < NSC; i++) begin
        msq[i] <= mag_in[i] * mag_in[i];
      end
    end
  end

  // dividend is square shifted up by the fraction bits; its top part is below the divisor
  always_comb begin
    dinit.piv = mpiv;
    dinit.rad = mrad;
    dinit.neg = mneg;
    for (int i = 0; i < NSC; i++) begin
      dinit.lane[i].rem = R_W'(msq[i][SQ_W-1:SQ_W-FRAC_BITS]);
      dinit.lane[i].num = {msq[i][SQ_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= Q_W; s++) dvld[s] <= 1'b0;
    end else if (adv) begin
      dvld[1] <= mv;
      for (int s = 2; s <= Q_W; s++) dvld[s] <= dvld[s-1];
    end
  end

  always_comb begin
    dnxt[1] = dinit;
    for (int i = 0; i < NSC; i++) begin
      dnxt[1].lane[i] = div_step(dinit.lane[i], dinit.rad);
    end
    for (int s = 2; s <= Q_W; s++) begin
      dnxt[s] = dstg[s-1];
      for (int i = 0; i < NSC; i++) begin
        dnxt[s].lane[i] = div_step(dstg[s-1].lane[i], dstg[s-1].rad);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= Q_W; s++) dstg[s] <= dnxt[s];
    end
  end

  // quotients and the pivot radicand enter the root lanes
  always_comb begin
    sinit.piv = dstg[Q_W].piv;
    sinit.neg = dstg[Q_W].neg;
    for (int i = 0; i < NSC; i++) begin
      sinit.lane[i].rem  = '0;
      sinit.lane[i].root = '0;
      sinit.lane[i].val  = dstg[Q_W].lane[i].num;
    end
    sinit.lane[NSC].rem  = '0;
    sinit.lane[NSC].root = '0;
    sinit.lane[NSC].val  = Q_W'({dstg[Q_W].rad, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= SR_W; s++) svld[s] <= 1'b0;
    end else if (adv) begin
      svld[1] <= dvld[Q_W];
      for (int s = 2; s <= SR_W; s++) svld[s] <= svld[s-1];
    end
  end

  always_comb begin
    snxt[1] = sinit;
    for (int i = 0; i < NSQ; i++) begin
      snxt[1].lane[i] = sqrt_step(sinit.lane[i]);
    end
    for (int s = 2; s <= SR_W; s++) begin
      snxt[s] = sstg[s-1];
      for (int i = 0; i < NSQ; i++) begin
        snxt[s].lane[i] = sqrt_step(sstg[s-1].lane[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= SR_W; s++) sstg[s] <= snxt[s];
    end
  end

  always_comb begin
    for (int i = 0; i < NSC; i++) begin
      qs[i] = rnd_sat(sstg[SR_W].lane[i].root, sstg[SR_W].neg[i]);
    end
    qs[NSC] = rnd_sat(sstg[SR_W].lane[NSC].root, 1'b0);
    unique case (sstg[SR_W].piv)
      PIV_W: begin
        qx = qs[0]; qy = qs[1]; qz = qs[2]; qw = qs[3];
      end
      PIV_X: begin
        qx = qs[3]; qy = qs[0]; qz = qs[1]; qw = qs[2];
      end
      PIV_Y: begin
        qx = qs[0]; qy = qs[3]; qz = qs[1]; qw = qs[2];
      end
      default: begin
        qx = qs[0]; qy = qs[1]; qz = qs[3]; qw = qs[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= svld[SR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {qw, qz, qy, qx};
    end
  end

endmodule

// ----- rtl/rm2q_checker.sv -----
// port-level checks for the converter, bound to the top level
`include "assert_macros.svh"

module rm2q_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [rm2q_pkg::DOUT_W-1:0] m_tdata
);

  `ASSERT_NEXT(a_out_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NEXT(a_out_hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `ASSERT_NEXT_ALWAYS(a_reset_no_out, clk, rst, !m_tvalid)
  `ASSERT_NEXT_ALWAYS(a_reset_ready, clk, rst, s_tready)

endmodule

bind rotation_matrix_to_quaternion_top rm2q_checker u_rm2q_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
